/* rtl/hfm_pkg.sv */
// ----------------------------------------------------------------------------
// hfm_pkg
// Shared widths and constants for the hysteresis frequency meter.
// ----------------------------------------------------------------------------
package hfm_pkg;

  // Averaging depth of the period ring and usable sample bits.
  localparam int AVG_DEPTH   = 10;
  localparam int SAMPLE_BITS = 12;

  // Field widths.
  localparam int SMP_W  = 12;
  localparam int TIME_W = 32;
  localparam int FREQ_W = 17;
  localparam int AVG_W  = 32;

  // Ring index and running sum widths.
  localparam int RING_IDX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int SUM_W      = TIME_W + ((AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1);

  // Divide-by-depth unit: two quotient bits per cycle.
  localparam int DIV_LEN   = 2 * ((SUM_W + 1) / 2);
  localparam int DIV_STEPS = DIV_LEN / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
  localparam int DREM_W    = $clog2(AVG_DEPTH) + 1;

  // Reciprocal unit: one quotient bit per cycle.
  localparam int RCP_CNT_W = $clog2(FREQ_W + 1);

  // Constants.
  localparam logic [FREQ_W-1:0] CENTI_KILO   = FREQ_W'(100000);
  localparam logic [SMP_W-1:0]  TH_HIGH_RST  = SMP_W'(1850);
  localparam logic [SMP_W-1:0]  TH_LOW_RST   = SMP_W'(1750);
  localparam logic [SMP_W-1:0]  SAMPLE_MASK  = SMP_W'((64'd1 << SAMPLE_BITS) - 64'd1);
  localparam logic [DREM_W:0]   DEPTH_DIV    = (DREM_W + 1)'(AVG_DEPTH);

  // Configuration register indexes.
  localparam logic [1:0] REG_ENABLE  = 2'd0;
  localparam logic [1:0] REG_TH_HIGH = 2'd1;
  localparam logic [1:0] REG_TH_LOW  = 2'd2;

endpackage

/* rtl/hfm_ring.sv */
// ----------------------------------------------------------------------------
// hfm_ring
// Ring of recent periods with a running sum, updated by a drop step then an add step.
// ----------------------------------------------------------------------------
module hfm_ring
  import hfm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TIME_W-1:0] period,
  output logic              done,
  output logic [SUM_W-1:0]  sum
);

  logic [TIME_W-1:0]     ring_r [AVG_DEPTH];
  logic [RING_IDX_W-1:0] pos_r;
  logic [RING_IDX_W-1:0] pos_nxt;
  logic [SUM_W-1:0]      sum_r;
  logic [TIME_W-1:0]     per_r;
  logic                  add_r;
  logic                  done_r;

  // Advance the write position with wrap.
  always_comb begin
    if (pos_r == RING_IDX_W'(AVG_DEPTH - 1)) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_r + RING_IDX_W'(1);
    end
  end

  // Start drops the old entry from the sum; the registered add step then adds the new period.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AVG_DEPTH; i++) begin
        ring_r[i] <= '0;
      end
      pos_r  <= '0;
      sum_r  <= '0;
      add_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        sum_r         <= sum_r - {{(SUM_W - TIME_W){1'b0}}, ring_r[pos_r]};
        ring_r[pos_r] <= period;
        pos_r         <= pos_nxt;
        add_r         <= 1'b1;
      end else if (add_r) begin
        sum_r  <= sum_r + {{(SUM_W - TIME_W){1'b0}}, per_r};
        add_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Period held for the add cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      per_r <= period;
    end
  end

  assign done = done_r;
  assign sum  = sum_r;

endmodule

/* rtl/hfm_avg.sv */
// ----------------------------------------------------------------------------
// hfm_avg
// Serial divide of the running sum by the ring depth, two bits per cycle.
// ----------------------------------------------------------------------------
module hfm_avg
  import hfm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] sum,
  output logic             done,
  output logic [AVG_W-1:0] avg
);

  logic [DIV_LEN-1:0]   dq_r;
  logic [DIV_LEN-1:0]   dq_nxt;
  logic [DREM_W-1:0]    rem_r;
  logic [DREM_W-1:0]    rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DREM_W:0]      t1;
  logic [DREM_W:0]      t2;
  logic [DREM_W-1:0]    r1;
  logic                 q1;
  logic                 q0;

  // Two restoring steps against the constant depth.
  always_comb begin
    t1 = {rem_r, dq_r[DIV_LEN-1]};
    q1 = (t1 >= DEPTH_DIV);
    r1 = q1 ? DREM_W'(t1 - DEPTH_DIV) : t1[DREM_W-1:0];
    t2 = {r1, dq_r[DIV_LEN-2]};
    q0 = (t2 >= DEPTH_DIV);
    rem_nxt = q0 ? DREM_W'(t2 - DEPTH_DIV) : t2[DREM_W-1:0];
    dq_nxt  = {dq_r[DIV_LEN-3:0], q1, q0};
  end

  // Control: step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out as quotient shifts in.
  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= DIV_LEN'(sum);
      rem_r <= '0;
    end else if (busy_r) begin
      dq_r  <= dq_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign avg  = dq_r[AVG_W-1:0];

endmodule

/* rtl/hfm_recip.sv */
// ----------------------------------------------------------------------------
// hfm_recip
// Serial restoring divide of the fixed scale by the average, one bit a cycle.
// ----------------------------------------------------------------------------
module hfm_recip
  import hfm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [AVG_W-1:0]  avg,
  output logic              done,
  output logic [FREQ_W-1:0] freq
);

  logic [FREQ_W-1:0]    q_r;
  logic [FREQ_W-1:0]    rem_r;
  logic [AVG_W-1:0]     dvs_r;
  logic                 zero_r;
  logic [RCP_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [FREQ_W:0]      t;
  logic                 ge;
  logic [FREQ_W-1:0]    rem_nxt;

  // One restoring step; the remainder never exceeds the scale.
  always_comb begin
    t  = {rem_r, q_r[FREQ_W-1]};
    ge = ({{(AVG_W - FREQ_W - 1){1'b0}}, t} >= dvs_r);
    if (ge) begin
      rem_nxt = FREQ_W'(t - dvs_r[FREQ_W:0]);
    end else begin
      rem_nxt = t[FREQ_W-1:0];
    end
  end

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= RCP_CNT_W'(FREQ_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - RCP_CNT_W'(1);
        if (cnt_r == RCP_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      q_r    <= CENTI_KILO;
      rem_r  <= '0;
      dvs_r  <= avg;
      zero_r <= (avg == '0);
    end else if (busy_r) begin
      q_r   <= {q_r[FREQ_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  // A zero average reports zero frequency.
  assign freq = zero_r ? '0 : q_r;

endmodule

/* rtl/hysteresis_frequency_meter.sv */
// ----------------------------------------------------------------------------
// hysteresis_frequency_meter
// Hysteresis edge detector, period ring average and frequency divide.
// A word that yields a result passes through the ring update, the
// divide-by-depth unit and the reciprocal unit into the output register,
// which raises out_tvalid; input is held off until the result is loaded.
// One word at a time: a word with no result leaves input ready, while a
// word with a result holds input off until any output stall clears. Reset
// clears the ring, the sum, the comparator state and restores the register
// reset values.
// ----------------------------------------------------------------------------
module hysteresis_frequency_meter
  import hfm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [11:0] sample, [43:12] time_ms, rest zero
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [16:0] freq_centihz, [48:17] period_ms, rest zero
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RING  = 3'd1;
  localparam logic [2:0] ST_AVG   = 3'd2;
  localparam logic [2:0] ST_RECIP = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]        state_r;
  logic              enable_r;
  logic [SMP_W-1:0]  th_high_r;
  logic [SMP_W-1:0]  th_low_r;
  logic              level_high_r;
  logic [TIME_W-1:0] prev_edge_r;
  logic [TIME_W-1:0] period_r;
  logic [FREQ_W-1:0] freq_r;
  logic              out_valid_r;
  logic [FREQ_W-1:0] out_freq_r;
  logic [TIME_W-1:0] out_period_r;

  logic              in_acc;
  logic [SMP_W-1:0]  smp;
  logic [TIME_W-1:0] now;
  logic [TIME_W-1:0] period;
  logic              edge_hit;
  logic              ring_start;
  logic              ring_done;
  logic [SUM_W-1:0]  sum;
  logic              avg_done;
  logic [AVG_W-1:0]  avg;
  logic              rcp_done;
  logic [FREQ_W-1:0] freq;
  logic              out_load;

  assign smp       = in_tdata[SMP_W-1:0] & SAMPLE_MASK;
  assign now       = in_tdata[SMP_W +: TIME_W];
  assign period    = now - prev_edge_r;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Rising edge: low state and sample strictly above the high threshold.
  assign edge_hit   = enable_r && !level_high_r && (smp > th_high_r);
  assign ring_start = in_acc && edge_hit && (prev_edge_r != '0);
  assign out_load   = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b0;
      th_high_r <= TH_HIGH_RST;
      th_low_r  <= TH_LOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLE:  enable_r  <= cfg_data[0];
        REG_TH_HIGH: th_high_r <= cfg_data;
        REG_TH_LOW:  th_low_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Comparator state and previous edge time.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_high_r <= 1'b0;
      prev_edge_r  <= '0;
    end else if (in_acc && enable_r) begin
      if (!level_high_r) begin
        if (smp > th_high_r) begin
          level_high_r <= 1'b1;
          prev_edge_r  <= now;
        end
      end else if (smp < th_low_r) begin
        level_high_r <= 1'b0;
      end
    end
  end

  // Sequencer over ring update, average and reciprocal.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      case (state_r)
        ST_IDLE:  if (ring_start) state_r <= ST_RING;
        ST_RING:  if (ring_done) state_r <= ST_AVG;
        ST_AVG:   if (avg_done) state_r <= ST_RECIP;
        ST_RECIP: if (rcp_done) state_r <= ST_OUT;
        ST_OUT:   if (out_load) state_r <= ST_IDLE;
        default:  state_r <= ST_IDLE;
      endcase
    end
  end

  // Working payload.
  always_ff @(posedge clk) begin
    if (ring_start) begin
      period_r <= period;
    end
    if (rcp_done) begin
      freq_r <= freq;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_freq_r   <= freq_r;
      out_period_r <= period_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_period_r, out_freq_r};

  hfm_ring u_ring (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ring_start),
    .period (period),
    .done   (ring_done),
    .sum    (sum)
  );

  hfm_avg u_avg (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ring_done),
    .sum   (sum),
    .done  (avg_done),
    .avg   (avg)
  );

  hfm_recip u_recip (
    .clk   (clk),
    .rst_n (rst_n),
    .start (avg_done),
    .avg   (avg),
    .done  (rcp_done),
    .freq  (freq)
  );

endmodule
